// ===== hw/rtl/pa_pkg.sv =====
package pa_pkg;

  localparam int CMD_W = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;

  // cells per first-level read group
  localparam int GRP_SIZE = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_READ   = 2'd2
  } pa_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } pa_in_t;

  typedef struct packed {
    logic                    ok;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] read_value;
  } pa_out_t;

  // operation broadcast to every cell, already qualified by position checks
  typedef struct packed {
    logic ins;
    logic ers;
    logic rd;
  } pa_op_t;

endpackage

// ===== hw/rtl/pa_cell.sv =====
module pa_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 7
) (
  input  logic                            clk,
  input  pa_pkg::pa_op_t                  op,
  input  logic [PW-1:0]                   pos,
  input  logic signed [pa_pkg::VAL_W-1:0] value,
  input  logic signed [pa_pkg::VAL_W-1:0] left_in,
  input  logic signed [pa_pkg::VAL_W-1:0] right_in,
  output logic signed [pa_pkg::VAL_W-1:0] entry_out,
  output logic signed [pa_pkg::VAL_W-1:0] rd_out
);
  import pa_pkg::*;

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;

  always_comb begin
    priority if (op.ins && (IDX > pos)) begin
      entry_nxt = left_in;
    end else if (op.ins && (IDX == pos)) begin
      entry_nxt = value;
    end else if (op.ers && (IDX >= pos)) begin
      entry_nxt = right_in;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;
  // masked so the read groups can simply or their members together
  assign rd_out = (op.rd && (IDX == pos)) ? entry_r : '0;

endmodule

// ===== hw/rtl/positional_insert_erase_array.sv =====
// channel | ports                          | beat
// --------+--------------------------------+------------------------------
// input   | in_valid, in_ready, in_data    | cmd, position, value
// output  | out_valid, out_ready, out_data | ok, count, read_value
//
// one beat per cycle unless stalled; results pass p_valid_r, out_valid_r.
// cells from pos on shift in the accept cycle; insert and erase end at once;
// a read passes a registered or tree: groups of 32 cells, then the groups.
// rst_n clears the count and the handshake state; entries are not reset.
// a stalled output holds its beat while one more command waits behind it.
module positional_insert_erase_array #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pa_pkg::pa_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pa_pkg::pa_out_t out_data
);
  import pa_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int NG = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           p_valid_r;
  logic           p_valid_nxt;
  logic           p_ok_r;
  logic [CW-1:0]  p_count_r;
  logic           out_valid_r;
  logic           out_valid_nxt;
  pa_out_t        out_data_r;

  logic           in_fire;
  logic           out_free;
  logic           p_adv;
  logic [PW-1:0]  pos_x;
  logic [PW-1:0]  cnt_x;
  logic           ins_ok;
  logic           ers_ok;
  logic           rd_ok;
  pa_op_t         op;

  logic signed [VAL_W-1:0] cell_entry [CAPACITY];
  logic signed [VAL_W-1:0] cell_rd    [NG*GRP_SIZE];
  logic signed [VAL_W-1:0] grp_or     [NG];
  logic signed [VAL_W-1:0] grp_r      [NG];
  logic signed [VAL_W-1:0] rd_word;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !p_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;
  assign p_adv    = p_valid_r && out_free;

  assign pos_x = PW'(in_data.position);
  assign cnt_x = PW'(count_r);

  assign ins_ok = (in_data.cmd == CMD_INSERT) && (pos_x <= cnt_x)
                  && (cnt_x < PW'(CAPACITY));
  assign ers_ok = (in_data.cmd == CMD_ERASE) && (pos_x < cnt_x);
  assign rd_ok  = (in_data.cmd == CMD_READ) && (pos_x < cnt_x);

  assign op.ins = in_fire && ins_ok;
  assign op.ers = in_fire && ers_ok;
  assign op.rd  = in_fire && rd_ok;

  always_comb begin
    priority if (op.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (op.ers) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // row of cells, each neighbor feeding the next for shifts
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = cell_entry[i];
    end else begin : g_mid_l
      assign left_w = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_entry[i];
    end else begin : g_mid_r
      assign right_w = cell_entry[i+1];
    end

    pa_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .pos       (pos_x),
      .value     (in_data.value),
      .left_in   (left_w),
      .right_in  (right_w),
      .entry_out (cell_entry[i]),
      .rd_out    (cell_rd[i])
    );
  end

  for (genvar i = CAPACITY; i < NG*GRP_SIZE; i++) begin : g_pad
    assign cell_rd[i] = '0;
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp_or[g] = grp_or[g] | cell_rd[g*GRP_SIZE+k];
      end
    end

    always_ff @(posedge clk) begin
      if (in_fire) begin
        grp_r[g] <= grp_or[g];
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NG; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (in_fire) begin
      p_valid_nxt = 1'b1;
    end else if (p_adv) begin
      p_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (p_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_ok_r    <= ins_ok || ers_ok || rd_ok;
      p_count_r <= count_nxt;
    end
    if (p_adv) begin
      out_data_r.ok         <= p_ok_r;
      out_data_r.count      <= CNT_W'(p_count_r);
      out_data_r.read_value <= rd_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/pa_chk.sv =====
module pa_chk #(
  parameter int CAPACITY = 64
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input pa_pkg::pa_in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input pa_pkg::pa_out_t out_data
);
  import pa_pkg::*;

  // a waiting input beat must hold
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while waiting");

  // a beat that stalls must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.read_value == '0)
    else $error("failed command returned nonzero read value");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.count) <= CAPACITY)
    else $error("count above capacity");

  // no result can leave straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind positional_insert_erase_array pa_chk #(.CAPACITY(CAPACITY)) u_pa_chk (.*);

// ===== sim/tb_top.sv =====
module tb_top;
  import pa_pkg::*;

  localparam int CAPACITY = 64;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  pa_in_t  in_data;
  logic    out_valid;
  logic    out_ready;
  pa_out_t out_data;

  positional_insert_erase_array #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // shadow copy of the array contents and fill level
  logic signed [VAL_W-1:0] shadow_words [CAPACITY];
  int                      shadow_len;

  pa_out_t awaited_results[$];
  pa_out_t oldest_result;

  logic idle_on;
  int   error_count;
  int   results_checked;
  int   ok_count;
  int   peak_len;
  int   cmd_tally [4];
  int   stuck_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // applies one command to the shadow array, returns the beat it should produce
  function automatic pa_out_t apply_list_command(input pa_in_t item);
    pa_out_t res;
    int      pos;
    res = '0;
    pos = item.position;
    case (item.cmd)
      CMD_INSERT: begin
        if (pos <= shadow_len && shadow_len < CAPACITY) begin
          for (int i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = item.value;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (pos < shadow_len) begin
          for (int i = pos + 1; i < shadow_len; i++) shadow_words[i-1] = shadow_words[i];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos < shadow_len) begin
          res.read_value = shadow_words[pos];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(shadow_len);
    return res;
  endfunction

  // called just after a falling edge, returns just after the falling edge
  // that follows acceptance
  task automatic send_command(input logic [CMD_W-1:0] op, input int pos,
                              input logic signed [VAL_W-1:0] val);
    pa_in_t  item;
    pa_out_t res;
    item.cmd = op;
    item.position = POS_W'(pos);
    item.value = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    res = apply_list_command(item);
    awaited_results.push_back(res);
    cmd_tally[op]++;
    if (res.ok) ok_count++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    @(negedge clk);
  endtask

  task automatic test_empty_array();
    send_command(CMD_READ, 0, 32'sd5);
    send_command(CMD_ERASE, 0, 32'sd0);
    send_command(CMD_INSERT, 1, 32'sd7);
    send_command(CMD_UNUSED, 0, -32'sd1);
  endtask

  task automatic test_extreme_values();
    send_command(CMD_INSERT, 0, 32'sh7FFF_FFFF);
    send_command(CMD_INSERT, 0, 32'sh8000_0000);
    send_command(CMD_INSERT, 2, -32'sd1);
    send_command(CMD_INSERT, 1, 32'sd0);
    // one past the end is the last legal insert slot, two past is not
    send_command(CMD_INSERT, 5, 32'sh1234_5678);
    for (int i = 0; i < 4; i++) send_command(CMD_READ, i, 32'sh5555_AAAA);
    send_command(CMD_READ, 4, 32'sd0);
    send_command(CMD_READ, CAPACITY, 32'sd0);
    send_command(CMD_ERASE, 4, 32'sd0);
    send_command(CMD_ERASE, 3, 32'sd0);
    send_command(CMD_ERASE, 0, 32'sd0);
    send_command(CMD_READ, 0, 32'sd0);
    send_command(CMD_READ, 1, 32'sd0);
    send_command(CMD_UNUSED, CAPACITY, 32'sh7FFF_FFFF);
    send_command(CMD_ERASE, 0, 32'sd0);
    send_command(CMD_ERASE, 0, 32'sd0);
  endtask

  task automatic test_fill_and_drain();
    while (shadow_len < CAPACITY)
      send_command(CMD_INSERT, $urandom_range(0, shadow_len), $urandom);
    send_command(CMD_INSERT, 0, $urandom);
    send_command(CMD_INSERT, CAPACITY, $urandom);
    send_command(CMD_INSERT, $urandom_range(1, CAPACITY - 1), $urandom);
    repeat (6) send_command(CMD_READ, $urandom_range(0, CAPACITY - 1), $urandom);
    send_command(CMD_READ, CAPACITY - 1, $urandom);
    send_command(CMD_READ, CAPACITY, $urandom);
    while (shadow_len > 0) begin
      if ($urandom_range(0, 3) == 0)
        send_command(CMD_READ, $urandom_range(0, shadow_len - 1), $urandom);
      send_command(CMD_ERASE, $urandom_range(0, shadow_len - 1), $urandom);
    end
    send_command(CMD_ERASE, 0, $urandom);
  endtask

  task automatic test_random_mix(input int n_items);
    int               pick;
    int               pos;
    logic [CMD_W-1:0] op;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) op = CMD_INSERT;
      else if (pick < 70) op = CMD_ERASE;
      else if (pick < 95) op = CMD_READ;
      else op = CMD_UNUSED;
      // mostly legal positions, a tenth anywhere from 0 up to CAPACITY
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, CAPACITY);
      else if (op == CMD_INSERT) pos = $urandom_range(0, shadow_len);
      else if (shadow_len == 0) pos = 0;
      else pos = $urandom_range(0, shadow_len - 1);
      send_command(op, pos, $urandom);
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result beat with nothing awaited");
      end else begin
        oldest_result = awaited_results.pop_front();
        if (out_data.ok !== oldest_result.ok)
          report_mismatch($sformatf("ok got %b want %b", out_data.ok, oldest_result.ok));
        if (out_data.count !== oldest_result.count)
          report_mismatch($sformatf("count got %0d want %0d",
                                    out_data.count, oldest_result.count));
        if (out_data.read_value !== oldest_result.read_value)
          report_mismatch($sformatf("read_value got %0d want %0d",
                                    out_data.read_value, oldest_result.read_value));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_on = 1'b1;
    shadow_len = 0;
    error_count = 0;
    results_checked = 0;
    ok_count = 0;
    peak_len = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_array();
    test_extreme_values();
    test_fill_and_drain();
    test_fill_and_drain();
    test_random_mix(450);
    // last stretch runs back to back on both sides
    idle_on = 1'b0;
    test_random_mix(60);
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", awaited_results.size()));

    $display("ran %0d inserts, %0d erases, %0d reads, %0d unused codes; %0d succeeded",
             cmd_tally[CMD_INSERT], cmd_tally[CMD_ERASE], cmd_tally[CMD_READ],
             cmd_tally[CMD_UNUSED], ok_count);
    $display("%0d result beats checked, array filled up to %0d of %0d entries",
             results_checked, peak_len, CAPACITY);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pa_pkg.sv
hw/rtl/pa_cell.sv
hw/rtl/positional_insert_erase_array.sv
hw/rtl/pa_chk.sv
sim/tb_top.sv
